### rtl/text_line_start_indexer_unit_macros.svh
// Assertion macros used by the checker of the line start indexer.
`ifndef TEXT_LINE_START_INDEXER_UNIT_MACROS_SVH
`define TEXT_LINE_START_INDEXER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lsi_pkg.sv
// Package with field widths, codes and shared types of the line start indexer.
package lsi_pkg;

  // Fixed widths of the transaction fields.
  localparam int MODE_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int LINE_W    = 16;
  localparam int COL_W     = 24;
  localparam int STATUS_W  = 2;
  localparam int OUT_OFF_W = 24;
  localparam int TOTAL_W   = 13;

  // Line break characters.
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_LINE_RANGE = 2'd1,
    STAT_COL_RANGE  = 2'd2,
    STAT_OVERFLOW   = 2'd3
  } status_t;

  // Control carried alongside an item through the query pipeline.
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  line_ok;
    logic  first;
    logic  last;
  } qry_ctl_t;

endpackage

### rtl/lsi_if.sv
// Request and response channel interfaces of the line start indexer.
interface lsi_req_if import lsi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [BYTE_W-1:0]   text_byte;
  logic [LINE_W-1:0]   line_idx;
  logic [COL_W-1:0]    column;

  modport source (output valid, output mode, output text_byte, output line_idx,
                  output column, input ready);
  modport sink   (input valid, input mode, input text_byte, input line_idx,
                  input column, output ready);
endinterface

interface lsi_rsp_if import lsi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [OUT_OFF_W-1:0] line_start;
  logic [OUT_OFF_W-1:0] line_length;
  logic [OUT_OFF_W-1:0] text_offset;
  logic [TOTAL_W-1:0]   lines_total;

  modport source (output valid, output status, output line_start, output line_length,
                  output text_offset, output lines_total, input ready);
  modport sink   (input valid, input status, input line_start, input line_length,
                  input text_offset, input lines_total, output ready);
endinterface

### rtl/lsi_start_mem.sv
// Line start table: one write port and two registered read ports.
module lsi_start_mem import lsi_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 25
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### rtl/lsi_tracker.sv
// Stream tracker: byte and line counts, CR state and table writes for appends.
module lsi_tracker import lsi_pkg::*; #(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 24,
  parameter int AW          = 12,
  parameter int TW          = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [MODE_W-1:0]      mode,
  input  logic [BYTE_W-1:0]      text_byte,
  output logic [TW-1:0]          tally,
  output logic [TW-1:0]          tally_next,
  output logic [OFFSET_BITS-1:0] bt_next,
  output logic                   ovf_next,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [OFFSET_BITS:0]   wr_data
);

  logic [OFFSET_BITS-1:0] bt;
  logic                   last_cr;
  logic                   ovf;
  logic                   last_cr_next;
  logic [TW-1:0]          tally_dec;

  assign tally_dec = tally - TW'(1);

  // Next state and table write for the accepted transaction.
  always_comb begin
    logic [OFFSET_BITS-1:0] pos1;
    logic                   full;
    tally_next   = tally;
    bt_next      = bt;
    last_cr_next = last_cr;
    ovf_next     = ovf;
    wr_en        = 1'b0;
    wr_addr      = tally[AW-1:0];
    pos1         = bt + OFFSET_BITS'(1);
    wr_data      = {1'b0, pos1};
    full         = (tally >= TW'(MAX_LINES));
    if (acc) begin
      unique case (mode_t'(mode))
        MODE_CLEAR: begin
          tally_next   = TW'(1);
          bt_next      = '0;
          last_cr_next = 1'b0;
          ovf_next     = 1'b0;
        end
        MODE_APPEND: begin
          priority if (bt == '1) begin
            // Offset limit reached: the byte is dropped.
            ovf_next = 1'b1;
          end else begin
            bt_next      = pos1;
            last_cr_next = 1'b0;
            priority if (text_byte == BYTE_LF && last_cr && tally >= TW'(2)) begin
              // LF after CR: move the open line past the LF, mark the line before.
              wr_en   = 1'b1;
              wr_addr = tally_dec[AW-1:0];
              wr_data = {1'b1, pos1};
            end else if (text_byte == BYTE_LF || text_byte == BYTE_CR) begin
              // Open a new line unless the table is full.
              if (full) begin
                ovf_next = 1'b1;
              end else begin
                wr_en        = 1'b1;
                tally_next   = tally + TW'(1);
                last_cr_next = (text_byte == BYTE_CR);
              end
            end else begin
              wr_en = 1'b0;
            end
          end
        end
        MODE_QUERY, MODE_NONE: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tally   <= TW'(1);
      bt      <= '0;
      last_cr <= 1'b0;
      ovf     <= 1'b0;
    end else begin
      tally   <= tally_next;
      bt      <= bt_next;
      last_cr <= last_cr_next;
      ovf     <= ovf_next;
    end
  end

endmodule

### rtl/lsi_query.sv
// Query pipeline: table read, line length, column check and response register.
module lsi_query import lsi_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int AW          = 12,
  parameter int TW          = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [MODE_W-1:0]      mode,
  input  logic [LINE_W-1:0]      line_idx,
  input  logic [COL_W-1:0]       column,
  input  logic [TW-1:0]          tally,
  input  logic [TW-1:0]          tally_next,
  input  logic [OFFSET_BITS-1:0] bt_next,
  input  logic                   ovf_next,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr_a,
  output logic [AW-1:0]          rd_addr_b,
  input  logic [OFFSET_BITS:0]   rd_data_a,
  input  logic [OFFSET_BITS:0]   rd_data_b,
  output logic                   ready,
  lsi_rsp_if.source              rsp
);

  localparam int LW = (TW > LINE_W) ? TW : LINE_W;
  localparam int CW = (OFFSET_BITS > COL_W) ? OFFSET_BITS : COL_W;

  logic                   adv;
  logic [LW-1:0]          ln_ext;
  logic [LW-1:0]          tl_ext;
  qry_ctl_t               in_ctl;

  qry_ctl_t               s1_ctl;
  logic [COL_W-1:0]       s1_col;
  logic [TW-1:0]          s1_tally;
  logic [OFFSET_BITS-1:0] s1_bt;
  logic                   s1_ovf;
  logic [OFFSET_BITS-1:0] s1_start;
  logic [OFFSET_BITS-1:0] s1_len;

  qry_ctl_t               s2_ctl;
  logic [COL_W-1:0]       s2_col;
  logic [TW-1:0]          s2_tally;
  logic                   s2_ovf;
  logic [OFFSET_BITS-1:0] s2_start;
  logic [OFFSET_BITS-1:0] s2_len;

  status_t                o_status;
  logic [OUT_OFF_W-1:0]   o_start;
  logic [OUT_OFF_W-1:0]   o_len;
  logic [OUT_OFF_W-1:0]   o_off;

  // The pipeline moves as a whole whenever the response register is free.
  // No request transaction is taken while reset is held.
  assign adv   = !rsp.valid || rsp.ready;
  assign ready = adv && !rst;

  // Line range check and table addresses for the incoming transaction.
  assign ln_ext         = LW'(line_idx);
  assign tl_ext         = LW'(tally);
  assign in_ctl.valid   = acc;
  assign in_ctl.mode    = mode_t'(mode);
  assign in_ctl.line_ok = (ln_ext < tl_ext);
  assign in_ctl.first   = (line_idx == '0);
  assign in_ctl.last    = ((ln_ext + LW'(1)) == tl_ext);
  assign rd_en          = acc && (mode_t'(mode) == MODE_QUERY);
  assign rd_addr_a      = line_idx[AW-1:0];
  assign rd_addr_b      = line_idx[AW-1:0] + AW'(1);

  // Stage one captures the transaction while the table is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col   <= column;
      s1_tally <= tally_next;
      s1_bt    <= bt_next;
      s1_ovf   <= ovf_next;
    end
  end

  // Content length: end is the next start less its terminator, or the byte count.
  always_comb begin
    logic [OFFSET_BITS-1:0] end_pos;
    logic [OFFSET_BITS:0]   diff;
    logic [OFFSET_BITS-1:0] dec;
    logic                   crlf;
    logic                   gt;
    s1_start = s1_ctl.first ? '0 : rd_data_a[OFFSET_BITS-1:0];
    end_pos  = s1_ctl.last ? s1_bt : rd_data_b[OFFSET_BITS-1:0];
    crlf     = rd_data_b[OFFSET_BITS];
    diff     = {1'b0, end_pos} - {1'b0, s1_start};
    gt       = !diff[OFFSET_BITS] && (diff[OFFSET_BITS-1:0] != '0);
    if (s1_ctl.last) begin
      dec = '0;
    end else if (crlf && diff[OFFSET_BITS-1:0] != OFFSET_BITS'(1)) begin
      dec = OFFSET_BITS'(2);
    end else begin
      dec = OFFSET_BITS'(1);
    end
    s1_len = gt ? (diff[OFFSET_BITS-1:0] - dec) : '0;
  end

  // Stage two holds start and length.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col   <= s1_col;
      s2_tally <= s1_tally;
      s2_ovf   <= s1_ovf;
      s2_start <= s1_start;
      s2_len   <= s1_len;
    end
  end

  // Column check, offset sum and status.
  always_comb begin
    o_status = s2_ovf ? STAT_OVERFLOW : STAT_OK;
    o_start  = '0;
    o_len    = '0;
    o_off    = '0;
    if (s2_ctl.mode == MODE_QUERY) begin
      priority if (!s2_ctl.line_ok) begin
        o_status = STAT_LINE_RANGE;
      end else if (CW'(s2_col) > CW'(s2_len)) begin
        o_status = STAT_COL_RANGE;
        o_start  = OUT_OFF_W'(s2_start);
        o_len    = OUT_OFF_W'(s2_len);
      end else begin
        o_start  = OUT_OFF_W'(s2_start);
        o_len    = OUT_OFF_W'(s2_len);
        o_off    = OUT_OFF_W'(s2_start) + s2_col;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.status      <= o_status;
      rsp.line_start  <= o_start;
      rsp.line_length <= o_len;
      rsp.text_offset <= o_off;
      rsp.lines_total <= TOTAL_W'(s2_tally);
    end
  end

endmodule

### rtl/text_line_start_indexer_unit.sv
// Top level of the text line start indexer.
//
// The block accepts one transaction per cycle whenever the response side is
// not stalled. Each response passes, in order, the registered read of the line
// start table, the line length stage and the column check into the response
// register. Appends and clears only touch counters, and appends write the table; a
// query reads two neighboring table rows at once, which sets the memory at one
// write and two read ports. Each table row holds a line's start offset and the
// CRLF mark of the line before it. Row zero is never stored and reads as zero,
// and only rows below the current line count are read, so the table needs no
// clearing pass after reset or a clear and the block is ready as soon as reset
// is released.
module text_line_start_indexer_unit import lsi_pkg::*; #(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  lsi_req_if.sink   req,
  lsi_rsp_if.source rsp
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int TW = $clog2(MAX_LINES + 1);

  logic                   acc;
  logic                   ready;
  logic [TW-1:0]          tally;
  logic [TW-1:0]          tally_next;
  logic [OFFSET_BITS-1:0] bt_next;
  logic                   ovf_next;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [OFFSET_BITS:0]   wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic [OFFSET_BITS:0]   rd_data_a;
  logic [OFFSET_BITS:0]   rd_data_b;

  // Request handshake.
  assign req.ready = ready;
  assign acc       = req.valid && ready;

  lsi_tracker #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS),
    .AW          (AW),
    .TW          (TW)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .mode       (req.mode),
    .text_byte  (req.text_byte),
    .tally      (tally),
    .tally_next (tally_next),
    .bt_next    (bt_next),
    .ovf_next   (ovf_next),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  lsi_start_mem #(
    .DEPTH (MAX_LINES),
    .AW    (AW),
    .DW    (OFFSET_BITS + 1)
  ) u_start_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  lsi_query #(
    .OFFSET_BITS (OFFSET_BITS),
    .AW          (AW),
    .TW          (TW)
  ) u_query (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .mode        (req.mode),
    .line_idx    (req.line_idx),
    .column      (req.column),
    .tally       (tally),
    .tally_next  (tally_next),
    .bt_next     (bt_next),
    .ovf_next    (ovf_next),
    .rd_en       (rd_en),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .ready       (ready),
    .rsp         (rsp)
  );

endmodule

### rtl/lsi_checker.sv
// Response port checker of the line start indexer and its bind to the top level.
`include "text_line_start_indexer_unit_macros.svh"

module lsi_checker import lsi_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [STATUS_W-1:0]  rsp_status,
  input logic [OUT_OFF_W-1:0] rsp_line_start,
  input logic [OUT_OFF_W-1:0] rsp_line_length,
  input logic [OUT_OFF_W-1:0] rsp_text_offset
);

  // A stalled response keeps its status, start and offset.
  `LSI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_line_start) && $stable(rsp_text_offset), "stalled response changed")

  // A line range error carries no start, length or offset.
  `LSI_ASSERT_NOW(a_line_err_zero, rsp_valid && rsp_status == STAT_LINE_RANGE, rsp_line_start == '0 && rsp_line_length == '0 && rsp_text_offset == '0, "line range error with data")

  // A column range error carries no offset.
  `LSI_ASSERT_NOW(a_col_err_zero, rsp_valid && rsp_status == STAT_COL_RANGE, rsp_text_offset == '0, "column range error with offset")

endmodule

bind text_line_start_indexer_unit lsi_checker u_lsi_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_line_start  (rsp.line_start),
  .rsp_line_length (rsp.line_length),
  .rsp_text_offset (rsp.text_offset)
);

### test/tb_top.sv
// Self-checking testbench for the text line start indexer.
module tb_top import lsi_pkg::*; ();

  localparam int TABLE_DEPTH = 4096;
  localparam longint unsigned OFFSET_LIMIT = (64'd1 << 24) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;

  // One response transaction as seen on the output channel.
  typedef struct {
    status_t                status;
    logic [OUT_OFF_W-1:0]   line_start;
    logic [OUT_OFF_W-1:0]   line_length;
    logic [OUT_OFF_W-1:0]   text_offset;
    logic [TOTAL_W-1:0]     lines_total;
  } lsi_answer_t;

  // Keeps its own line index and compares responses in order against it.
  class line_index_scoreboard;
    logic [OUT_OFF_W-1:0] starts [TABLE_DEPTH];
    bit                   crlf_line [TABLE_DEPTH];
    int unsigned          n_lines;
    longint unsigned      n_bytes;
    bit                   after_cr;
    bit                   ovf;
    lsi_answer_t          answers [$];
    int                   errors;

    function new();
      errors = 0;
      clear_index();
    endfunction

    function void clear_index();
      n_lines = 1;
      n_bytes = 0;
      after_cr = 0;
      ovf = 0;
      starts[0] = '0;
    endfunction

    // Opens a line at the given offset unless the table is full.
    function bit open_line(longint unsigned start);
      if (n_lines >= TABLE_DEPTH) begin
        ovf = 1;
        return 0;
      end
      crlf_line[n_lines - 1] = 0;
      starts[n_lines] = start[OUT_OFF_W-1:0];
      n_lines++;
      return 1;
    endfunction

    function void add_text_byte(logic [BYTE_W-1:0] b);
      longint unsigned pos;
      bit cr_now;
      cr_now = 0;
      if (n_bytes >= OFFSET_LIMIT) begin
        ovf = 1;
        return;
      end
      pos = n_bytes;
      n_bytes = (n_bytes + 1) & OFFSET_LIMIT;
      if (b == BYTE_LF) begin
        // An LF right after a line-opening CR moves that start past itself.
        if (after_cr && n_lines >= 2) begin
          starts[n_lines - 1] = pos[OUT_OFF_W-1:0] + 1'b1;
          crlf_line[n_lines - 2] = 1;
        end else begin
          void'(open_line(pos + 1));
        end
      end else if (b == BYTE_CR) begin
        cr_now = open_line(pos + 1);
      end
      after_cr = cr_now;
    endfunction

    function lsi_answer_t answer_query(logic [LINE_W-1:0] ln, logic [COL_W-1:0] col);
      lsi_answer_t a;
      longint unsigned s;
      longint unsigned nx;
      longint unsigned e;
      longint unsigned len;
      a.status = STAT_LINE_RANGE;
      a.line_start = '0;
      a.line_length = '0;
      a.text_offset = '0;
      a.lines_total = '0;
      if (ln >= n_lines) return a;
      s = starts[ln];
      // Inner lines end before the next start, less the CR of a CRLF pair.
      if (ln + 1 < n_lines) begin
        nx = starts[ln + 1];
        e = (nx > s) ? nx - 1 : s;
        if (crlf_line[ln] && e > s) e = e - 1;
      end else begin
        e = (n_bytes > s) ? n_bytes : s;
      end
      len = e - s;
      a.line_start = s[OUT_OFF_W-1:0];
      a.line_length = len[OUT_OFF_W-1:0];
      if (col > len) begin
        a.status = STAT_COL_RANGE;
      end else begin
        a.text_offset = s[OUT_OFF_W-1:0] + col;
        a.status = ovf ? STAT_OVERFLOW : STAT_OK;
      end
      return a;
    endfunction

    // Called for every accepted request transaction.
    function void note_request(mode_t m, logic [BYTE_W-1:0] b, logic [LINE_W-1:0] ln,
                               logic [COL_W-1:0] col);
      lsi_answer_t a;
      a.status = STAT_OK;
      a.line_start = '0;
      a.line_length = '0;
      a.text_offset = '0;
      case (m)
        MODE_CLEAR:  clear_index();
        MODE_APPEND: add_text_byte(b);
        MODE_QUERY:  a = answer_query(ln, col);
        default:     ;
      endcase
      if (m != MODE_QUERY) a.status = ovf ? STAT_OVERFLOW : STAT_OK;
      a.lines_total = n_lines[TOTAL_W-1:0];
      answers.insert(answers.size(), a);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted response transaction.
    function void check_response(lsi_answer_t got);
      lsi_answer_t want;
      if (answers.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d lines %0d",
                 $time, got.status, got.lines_total);
        errors++;
        return;
      end
      want = answers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("line_start", want.line_start, got.line_start);
      compare_field("line_length", want.line_length, got.line_length);
      compare_field("text_offset", want.text_offset, got.text_offset);
      compare_field("lines_total", want.lines_total, got.lines_total);
    endfunction

    function int outstanding();
      return answers.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;
  int   lines_hint;

  lsi_req_if req_ch ();
  lsi_rsp_if rsp_ch ();

  line_index_scoreboard idx = new();

  text_line_start_indexer_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Observe both channels and feed the scoreboard.
  always @(posedge clk) begin : observe
    lsi_answer_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        idx.note_request(mode_t'(req_ch.mode), req_ch.text_byte, req_ch.line_idx,
                         req_ch.column);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = status_t'(rsp_ch.status);
        got.line_start = rsp_ch.line_start;
        got.line_length = rsp_ch.line_length;
        got.text_offset = rsp_ch.text_offset;
        got.lines_total = rsp_ch.lines_total;
        idx.check_response(got);
      end
    end
  end

  // Response side: a random stall ahead of each transaction unless steady is set.
  initial begin : receiver
    int hold;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Drives one request transaction after a random gap and waits for acceptance.
  task automatic send_item(mode_t m, logic [BYTE_W-1:0] b, logic [LINE_W-1:0] ln,
                           logic [COL_W-1:0] col);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.text_byte <= b;
    req_ch.line_idx <= ln;
    req_ch.column <= col;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic append_text(logic [BYTE_W-1:0] b);
    send_item(MODE_APPEND, b, 16'($urandom), 24'($urandom));
    if (b == BYTE_LF || b == BYTE_CR) lines_hint++;
  endtask

  task automatic query_line(logic [LINE_W-1:0] ln, logic [COL_W-1:0] col);
    send_item(MODE_QUERY, 8'($urandom), ln, col);
  endtask

  task automatic clear_all();
    send_item(MODE_CLEAR, 8'($urandom), 16'($urandom), 24'($urandom));
    lines_hint = 1;
  endtask

  // Holds the request side idle until every response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (idx.outstanding() != 0);
  endtask

  // Text bytes biased toward line breaks so lines stay short.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return BYTE_LF;
    if (r < 24) return BYTE_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Main stimulus sequence.
  initial begin : stimulus
    int r;
    steady = 1'b0;
    cycles = 0;
    lines_hint = 1;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_CLEAR;
    req_ch.text_byte <= '0;
    req_ch.line_idx <= '0;
    req_ch.column <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Queries on the empty index, including the field extremes.
    query_line(16'd0, 24'd0);
    query_line(16'd0, 24'd1);
    query_line(16'd1, 24'd0);
    query_line(16'hFFFF, 24'hFFFFFF);

    // CRLF, lone CR, LF, an empty line and a last line without a break.
    append_text(8'h61);
    append_text(BYTE_CR);
    append_text(BYTE_LF);
    append_text(8'h62);
    append_text(BYTE_CR);
    append_text(8'h63);
    append_text(BYTE_LF);
    append_text(BYTE_LF);
    append_text(8'hFF);
    append_text(8'h00);
    query_line(16'd0, 24'd1);
    query_line(16'd0, 24'd2);
    query_line(16'd1, 24'd1);
    query_line(16'd2, 24'd1);
    query_line(16'd3, 24'd0);
    query_line(16'd4, 24'd2);
    query_line(16'd4, 24'd3);
    query_line(16'd3, 24'hFFFFFF);
    send_item(MODE_NONE, 8'hFF, 16'hFFFF, 24'hFFFFFF);
    clear_all();
    query_line(16'd0, 24'd0);

    // Random text with interleaved queries, clears and idle modes.
    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 1) begin
        clear_all();
      end else if (r < 2) begin
        send_item(MODE_NONE, 8'($urandom), 16'($urandom), 24'($urandom));
      end else if (r < 70) begin
        append_text(pick_byte());
      end else if (r < 92) begin
        query_line(16'($urandom_range(0, lines_hint)), 24'($urandom_range(0, 12)));
      end else if (r < 96) begin
        query_line(16'($urandom_range(0, lines_hint)), 24'($urandom));
      end else begin
        query_line(16'($urandom), 24'($urandom_range(0, 12)));
      end
    end
    steady = 1'b0;

    // Fill the line table, with a CRLF pair right at its top.
    drain();
    clear_all();
    repeat (TABLE_DEPTH - 3) append_text(BYTE_LF);
    append_text(BYTE_CR);
    append_text(BYTE_LF);
    append_text(BYTE_LF);
    // Breaks past a full table are dropped and raise overflow.
    append_text(BYTE_CR);
    append_text(BYTE_LF);
    append_text(8'h78);
    query_line(16'(TABLE_DEPTH - 1), 24'd0);
    query_line(16'(TABLE_DEPTH - 1), 24'd3);
    query_line(16'(TABLE_DEPTH - 1), 24'd4);
    query_line(16'(TABLE_DEPTH - 2), 24'd0);
    query_line(16'(TABLE_DEPTH - 3), 24'd0);
    query_line(16'(TABLE_DEPTH), 24'd0);
    query_line(16'hFFFF, 24'd0);
    repeat (20) query_line(16'($urandom_range(0, TABLE_DEPTH - 1)), 24'($urandom_range(0, 1)));
    send_item(MODE_NONE, 8'($urandom), 16'($urandom), 24'($urandom));
    append_text(8'h79);
    // Overflow holds until a clear.
    clear_all();
    append_text(BYTE_CR);
    query_line(16'd1, 24'd0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (idx.errors == 0 && idx.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
